[rtl/range_product_sign_tree_core_assert.svh]
// assertion macros for the sign tree sequencer
`ifndef RANGE_PRODUCT_SIGN_TREE_CORE_ASSERT_SVH
`define RANGE_PRODUCT_SIGN_TREE_CORE_ASSERT_SVH

// same-cycle implication, checked on clk and off during rst
`define RPST_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk and off during rst
`define RPST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/rpst_pkg.sv]
package rpst_pkg;

  // tree size
  localparam int MAX_ELEMENTS = 1024;
  localparam int TREE_DEPTH   = 2 * MAX_ELEMENTS;
  localparam int LEAF_W       = $clog2(MAX_ELEMENTS);
  localparam int NODE_W       = LEAF_W + 1;
  localparam int QRY_W        = NODE_W + 1;

  // field widths
  localparam int POS_W   = 10;
  localparam int VALUE_W = 32;
  localparam int CNT_W   = 11;
  localparam int CMP_W   = (CNT_W > NODE_W) ? CNT_W : NODE_W;

  // configuration port
  localparam int APB_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 3;
  localparam logic [CNT_W-1:0] ELEMENT_COUNT_RESET = CNT_W'(1024);

  typedef logic [CFG_ADDR_W-3:0] reg_index_t;
  localparam reg_index_t REG_ELEMENT_COUNT = reg_index_t'(0);

  // commands
  typedef enum logic {
    CMD_SET   = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  // signs
  typedef logic signed [1:0] sign_t;
  localparam sign_t SIGN_ZERO = 2'sb00;
  localparam sign_t SIGN_POS  = 2'sb01;
  localparam sign_t SIGN_NEG  = 2'sb11;

  typedef logic [NODE_W-1:0] node_addr_t;

  // memory request from the sequencer
  typedef struct packed {
    logic       we;
    node_addr_t waddr;
    sign_t      wdata;
    logic       re;
    node_addr_t raddr;
  } ram_req_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SET_UP,
    ST_Q_L,
    ST_Q_R,
    ST_Q_RW,
    ST_DONE
  } state_t;

  // product of two signs
  function automatic sign_t sign_mul(sign_t a, sign_t b);
    sign_t res;
    if ((a == SIGN_ZERO) || (b == SIGN_ZERO)) begin
      res = SIGN_ZERO;
    end else if (a[1] ^ b[1]) begin
      res = SIGN_NEG;
    end else begin
      res = SIGN_POS;
    end
    return res;
  endfunction

  // sign of a signed value
  function automatic sign_t sign_of(logic signed [VALUE_W-1:0] v);
    sign_t res;
    if (v == '0) begin
      res = SIGN_ZERO;
    end else if (v[VALUE_W-1]) begin
      res = SIGN_NEG;
    end else begin
      res = SIGN_POS;
    end
    return res;
  endfunction

endpackage

[rtl/rpst_if.sv]
// command channel
interface rpst_in_if
  import rpst_pkg::*;
  ();
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [POS_W-1:0]            position;
  logic [POS_W-1:0]            range_end;
  logic signed [VALUE_W-1:0]   value;

  modport source (output valid, command, position, range_end, value, input ready);
  modport sink (input valid, command, position, range_end, value, output ready);
endinterface

// result channel
interface rpst_out_if
  import rpst_pkg::*;
  ();
  logic  valid;
  logic  ready;
  sign_t product_sign;
  logic  range_error;

  modport source (output valid, product_sign, range_error, input ready);
  modport sink (input valid, product_sign, range_error, output ready);
endinterface

[rtl/rpst_ram.sv]
// simple dual-port ram, registered read
module rpst_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/rpst_cfg.sv]
module rpst_cfg
  import rpst_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [CMP_W-1:0]      count_eff
);

  logic [CNT_W-1:0] element_count;
  reg_index_t       reg_index;

  assign reg_index = paddr[CFG_ADDR_W-1:2];
  assign pready    = 1'b1;

  // register write
  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= ELEMENT_COUNT_RESET;
    end else if (psel && penable && pwrite && (reg_index == REG_ELEMENT_COUNT)) begin
      element_count <= pwdata[CNT_W-1:0];
    end
  end

  // register read
  always_comb begin
    if (reg_index == REG_ELEMENT_COUNT) begin
      prdata = APB_DATA_W'(element_count);
    end else begin
      prdata = '0;
    end
  end

  // count in use, capped at the tree size
  always_comb begin
    if (CMP_W'(element_count) < CMP_W'(MAX_ELEMENTS)) begin
      count_eff = CMP_W'(element_count);
    end else begin
      count_eff = CMP_W'(MAX_ELEMENTS);
    end
  end

endmodule

[rtl/rpst_ctrl.sv]
module rpst_ctrl
  import rpst_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [CMP_W-1:0]  count_eff,
  rpst_in_if.sink           in_ch,
  rpst_out_if.source        out_ch,
  output ram_req_t          ram_req,
  input  sign_t             rdata
);

  `include "range_product_sign_tree_core_assert.svh"

  state_t           state, state_next;
  node_addr_t       clr_addr, clr_addr_next;
  node_addr_t       node, node_next;
  sign_t            cur, cur_next;
  logic [QRY_W-1:0] ql, ql_next;
  logic [QRY_W-1:0] qr, qr_next;
  sign_t            acc, acc_next;
  logic             lpend, lpend_next;
  sign_t            res_sign, res_sign_next;
  logic             res_err, res_err_next;

  logic             accept;
  logic             load_out;
  node_addr_t       leaf;
  node_addr_t       parent;
  sign_t            prod;
  sign_t            acc_mid;

  assign in_ch.ready = (state == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign leaf        = node_addr_t'(MAX_ELEMENTS) + node_addr_t'(in_ch.position);
  assign parent      = node >> 1;
  assign prod        = sign_mul(cur, rdata);
  assign acc_mid     = lpend ? sign_mul(acc, rdata) : acc;

  // state and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
    end
    node     <= node_next;
    cur      <= cur_next;
    ql       <= ql_next;
    qr       <= qr_next;
    acc      <= acc_next;
    lpend    <= lpend_next;
    res_sign <= res_sign_next;
    res_err  <= res_err_next;
  end

  // sequencer
  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    node_next     = node;
    cur_next      = cur;
    ql_next       = ql;
    qr_next       = qr;
    acc_next      = acc;
    lpend_next    = lpend;
    res_sign_next = res_sign;
    res_err_next  = res_err;
    load_out      = 1'b0;
    ram_req       = '0;
    unique case (state)
      ST_CLEAR: begin
        // zero every node once after reset
        ram_req.we    = 1'b1;
        ram_req.waddr = clr_addr;
        ram_req.wdata = SIGN_ZERO;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == node_addr_t'(TREE_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (cmd_t'(in_ch.command) == CMD_SET) begin
            // write leaf, fetch its sibling
            if (CMP_W'(in_ch.position) < count_eff) begin
              ram_req.we    = 1'b1;
              ram_req.waddr = leaf;
              ram_req.wdata = sign_of(in_ch.value);
              ram_req.re    = 1'b1;
              ram_req.raddr = leaf ^ node_addr_t'(1);
              node_next     = leaf;
              cur_next      = sign_of(in_ch.value);
              state_next    = ST_SET_UP;
            end
          end else begin
            if ((in_ch.position > in_ch.range_end)
                || (CMP_W'(in_ch.range_end) >= count_eff)) begin
              res_sign_next = SIGN_ZERO;
              res_err_next  = 1'b1;
              state_next    = ST_DONE;
            end else begin
              ql_next    = QRY_W'(MAX_ELEMENTS) + QRY_W'(in_ch.position);
              qr_next    = QRY_W'(MAX_ELEMENTS) + QRY_W'(in_ch.range_end) + QRY_W'(1);
              acc_next   = SIGN_POS;
              state_next = ST_Q_L;
            end
          end
        end
      end
      ST_SET_UP: begin
        // parent gets product of path node and sibling
        ram_req.we    = 1'b1;
        ram_req.waddr = parent;
        ram_req.wdata = prod;
        cur_next      = prod;
        node_next     = parent;
        if (parent == node_addr_t'(1)) begin
          state_next = ST_IDLE;
        end else begin
          ram_req.re    = 1'b1;
          ram_req.raddr = parent ^ node_addr_t'(1);
        end
      end
      ST_Q_L: begin
        // left border of the current level
        if (ql < qr) begin
          lpend_next = ql[0];
          if (ql[0]) begin
            ram_req.re    = 1'b1;
            ram_req.raddr = ql[NODE_W-1:0];
            ql_next       = ql + QRY_W'(1);
          end
          state_next = ST_Q_R;
        end else begin
          res_sign_next = acc;
          res_err_next  = 1'b0;
          state_next    = ST_DONE;
        end
      end
      ST_Q_R: begin
        // right border of the current level
        acc_next = acc_mid;
        if (qr[0]) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = qr[NODE_W-1:0] - node_addr_t'(1);
          qr_next       = qr - QRY_W'(1);
          state_next    = ST_Q_RW;
        end else begin
          ql_next    = ql >> 1;
          qr_next    = qr >> 1;
          state_next = ST_Q_L;
        end
      end
      ST_Q_RW: begin
        acc_next   = sign_mul(acc, rdata);
        ql_next    = ql >> 1;
        qr_next    = qr >> 1;
        state_next = ST_Q_L;
      end
      ST_DONE: begin
        // hand result to the output register when it is free
        if (!out_ch.valid || out_ch.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (load_out) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
    if (load_out) begin
      out_ch.product_sign <= res_sign;
      out_ch.range_error  <= res_err;
    end
  end

  `RPST_ASSERT_NOW(a_no_same_entry, ram_req.we && ram_req.re, ram_req.waddr != ram_req.raddr, "read and write hit one node")
  `RPST_ASSERT_NOW(a_clear_blocks, state == ST_CLEAR, !in_ch.ready, "item taken during clearing")
  `RPST_ASSERT_NOW(a_query_order, state == ST_Q_R || state == ST_Q_RW, ql <= qr + QRY_W'(1), "query borders crossed")
  `RPST_ASSERT_NOW(a_err_zero, out_ch.valid && out_ch.range_error, out_ch.product_sign == SIGN_ZERO, "error result with nonzero sign")
  `RPST_ASSERT_NEXT(a_set_walks_up, state == ST_SET_UP && parent != node_addr_t'(1), state == ST_SET_UP, "update walk cut short")

endmodule

[rtl/range_product_sign_tree_core.sv]
// Sign tree over up to 1024 elements kept in one 2048 x 2-bit ram (node 1
// is the root, element k sits at node 1024+k). After reset the block clears
// the whole ram, one node per cycle, and takes no item until it is done;
// configuration writes are taken meanwhile. A set item writes its leaf and
// then one ancestor per cycle, and returns no result; one at or beyond
// element_count is dropped. A query item walks the tree from the leaves to
// the root reading at most two border nodes per level through the single
// read port, and its result then goes to the output register; a bad range
// answers with range_error set. The walk through the ram sets the rate: one
// item is worked on at a time, while the previous result may still wait in
// the output register. element_count is the only register, at byte
// address 0.
module range_product_sign_tree_core
  import rpst_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  rpst_in_if.sink               in_ch,
  rpst_out_if.source            out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [CMP_W-1:0] count_eff;
  ram_req_t         ram_req;
  logic [1:0]       ram_rdata;

  // configuration register
  rpst_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .count_eff (count_eff)
  );

  // update and query sequencer
  rpst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .count_eff (count_eff),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .ram_req   (ram_req),
    .rdata     (sign_t'(ram_rdata))
  );

  // sign tree storage
  rpst_ram #(
    .WIDTH (2),
    .DEPTH (TREE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

endmodule
